### src/x86de_pkg.sv
// x86de_pkg: shared types and constants for the 16-bit x86 decode/execute block
// no dependencies
package x86de_pkg;

  localparam logic [2:0] OPK_MOV  = 3'd0;
  localparam logic [2:0] OPK_ADD  = 3'd1;
  localparam logic [2:0] OPK_ADC  = 3'd2;
  localparam logic [2:0] OPK_SUB  = 3'd3;
  localparam logic [2:0] OPK_SBB  = 3'd4;
  localparam logic [2:0] OPK_CMP  = 3'd5;
  localparam logic [2:0] OPK_JMP  = 3'd6;
  localparam logic [2:0] OPK_NONE = 3'd7;

  localparam logic [1:0] ST_EXEC  = 2'd0;
  localparam logic [1:0] ST_DEC   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  localparam logic [5:0] ROW_ARITH_IMM  = 6'h20;
  localparam logic [5:0] ROW_MOV_IMM_RM = 6'h31;
  localparam logic [5:0] ROW_MOV_ACC    = 6'h28;

  // decoded item handed from front to back
  typedef struct packed {
    logic [2:0]  len;
    logic [1:0]  status;
    logic [2:0]  kind;
    logic        exec;     // status is executed
    logic [4:0]  dst;
    logic        src_imm;  // source is the immediate
    logic [4:0]  src;
    logic [15:0] imm;
  } dec_t;

endpackage

### src/x86de_front.sv
// x86de_front: length decode and classification of one instruction window
// depends on x86de_pkg
module x86de_front (
  input  logic [47:0]         instr_bytes,
  input  logic [2:0]          bytes_valid,
  output x86de_pkg::dec_t     dec
);
  import x86de_pkg::*;

  logic [7:0] b0, b1, b2, b3;
  logic [5:0] op6;
  logic       d, w, ww;
  logic [1:0] md;
  logic [2:0] rg, rm, nv, len;
  logic       bad, modrm, mem, immrm, seg, ireg, acc, jmp;
  logic [2:0] kind;

  assign b0 = instr_bytes[7:0];
  assign b1 = instr_bytes[15:8];
  assign b2 = instr_bytes[23:16];
  assign b3 = instr_bytes[31:24];
  assign op6 = b0[7:2];
  assign d = b0[1];
  assign w = b0[0];
  assign ww = b0[3];
  assign md = b1[7:6];
  assign rg = b1[5:3];
  assign rm = b1[2:0];

  // classify and size
  always_comb begin
    logic [2:0] disp;
    nv = (bytes_valid > 3'd6) ? 3'd6 : bytes_valid;
    bad = 1'b0; modrm = 1'b0; immrm = 1'b0; seg = 1'b0; ireg = 1'b0;
    acc = 1'b0; jmp = 1'b0; kind = OPK_NONE;
    case (op6)
      6'h22: begin modrm = 1'b1; kind = OPK_MOV; end
      6'h23: begin
        if (b0 == 8'h8C || b0 == 8'h8E) begin seg = 1'b1; modrm = 1'b1; kind = OPK_MOV; end
        else bad = 1'b1;
      end
      6'h00: begin modrm = 1'b1; kind = OPK_ADD; end
      6'h0A: begin modrm = 1'b1; kind = OPK_SUB; end
      6'h0E: begin modrm = 1'b1; kind = OPK_CMP; end
      6'h01: begin acc = ~d; bad = d; kind = OPK_ADD; end
      6'h0B: begin acc = ~d; bad = d; kind = OPK_SUB; end
      6'h0F: begin acc = ~d; bad = d; kind = OPK_CMP; end
      ROW_MOV_ACC: begin acc = 1'b1; kind = OPK_MOV; end
      ROW_MOV_IMM_RM: begin immrm = d; modrm = d; bad = ~d; kind = OPK_MOV; end
      ROW_ARITH_IMM: begin
        immrm = 1'b1; modrm = 1'b1;
        case (rg)
          3'd0: kind = OPK_ADD;
          3'd2: kind = OPK_ADC;
          3'd3: kind = OPK_SBB;
          3'd5: kind = OPK_SUB;
          3'd7: kind = OPK_CMP;
          default: kind = OPK_NONE;
        endcase
      end
      6'h2C, 6'h2D, 6'h2E, 6'h2F: begin ireg = 1'b1; kind = OPK_MOV; end
      6'h1C, 6'h1D, 6'h1E, 6'h1F, 6'h38: begin jmp = 1'b1; kind = OPK_JMP; end
      default: bad = 1'b1;
    endcase
    disp = (md == 2'd0) ? ((rm == 3'd6) ? 3'd2 : 3'd0) :
           (md == 2'd1) ? 3'd1 : (md == 2'd2) ? 3'd2 : 3'd0;
    mem = 1'b0;
    len = 3'd0;
    if (acc) begin
      len = (op6 == ROW_MOV_ACC || w) ? 3'd3 : 3'd2; mem = 1'b1;
    end else if (jmp) begin
      len = 3'd2; mem = 1'b1;
    end else if (ireg) begin
      len = 3'd2 + {2'd0, ww};
    end else begin
      mem = (md != 2'd3);
      len = 3'd2 + disp;
      if (immrm) len = len + 3'd1 + {2'd0, (op6 == ROW_ARITH_IMM) ? (b0 == 8'h81) : w};
    end
  end

  // status and operand selection
  always_comb begin
    logic [4:0] rc, mc;
    dec = '0;
    dec.kind = OPK_NONE;
    rc = w ? {2'b00, rg} : {2'b01, rg};
    mc = w ? {2'b00, rm} : {2'b01, rm};
    if (nv == 3'd0) dec.status = ST_TRUNC;
    else if (bad) dec.status = ST_UNSUP;
    else if (modrm && nv < 3'd2) dec.status = ST_TRUNC;
    else if (immrm && kind == OPK_NONE) dec.status = ST_UNSUP;
    else if (nv < len) dec.status = ST_TRUNC;
    else begin
      dec.len = len;
      dec.kind = kind;
      dec.status = mem ? ST_DEC : ST_EXEC;
      dec.exec = ~mem;
    end
    if (seg) begin
      dec.dst = d ? {3'b100, rg[1:0]} : {2'b00, rm};
      dec.src = d ? {2'b00, rm} : {3'b100, rg[1:0]};
    end else if (immrm) begin
      dec.dst = mc;
      dec.src_imm = 1'b1;
      if (len == 3'd4) dec.imm = {b3, b2};
      else if (b0 == 8'h83) dec.imm = {{8{b2[7]}}, b2};
      else dec.imm = {8'h00, b2};
    end else if (ireg) begin
      dec.dst = ww ? {2'b00, b0[2:0]} : {2'b01, b0[2:0]};
      dec.src_imm = 1'b1;
      dec.imm = ww ? {b2, b1} : {8'h00, b1};
    end else begin
      dec.dst = d ? rc : mc;
      dec.src = d ? mc : rc;
    end
  end

endmodule

### src/x86de_back.sv
// x86de_back: register file, alu, flags and result register
// depends on x86de_pkg
module x86de_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  x86de_pkg::dec_t q_dec,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata
);
  import x86de_pkg::*;

  logic [15:0] gr_r [8];
  logic [15:0] sr_r [4];
  logic [2:0]  fl_r;
  logic        ov_r;
  logic [39:0] od_r;

  function automatic logic [15:0] rd(input logic [4:0] c, input logic [15:0] g [8],
                                     input logic [15:0] s [4]);
    logic [15:0] v;
    if (c[4]) v = s[c[1:0]];
    else if (!c[3]) v = g[c[2:0]];
    else if (!c[2]) v = {8'h00, g[{1'b0, c[1:0]}][7:0]};
    else v = {8'h00, g[{1'b0, c[1:0]}][15:8]};
    return v;
  endfunction

  logic        take, wide, fw, rw;
  logic [15:0] a, s, r, nv;
  logic [2:0]  fl_nxt;

  assign q_ready = ~ov_r | out_tready;
  assign take = q_valid & q_ready;

  // execute
  always_comb begin
    wide = ~q_dec.dst[3] | q_dec.dst[4];
    a = rd(q_dec.dst, gr_r, sr_r);
    s = q_dec.src_imm ? q_dec.imm : rd(q_dec.src, gr_r, sr_r);
    if (!wide) s = {8'h00, s[7:0]};
    if (q_dec.kind == OPK_MOV) r = s;
    else if (q_dec.kind == OPK_ADD || q_dec.kind == OPK_ADC) r = a + s;
    else r = a - s;
    if (!wide) r = {8'h00, r[7:0]};
    fw = q_dec.exec & (q_dec.kind != OPK_MOV);
    rw = q_dec.exec & (q_dec.kind != OPK_CMP);
    fl_nxt = fw ? {~^r[7:0], wide ? r[15] : r[7], r == 16'h0000} : fl_r;
    if (q_dec.dst[4] || !q_dec.dst[3]) nv = r;
    else if (!q_dec.dst[2]) nv = {gr_r[{1'b0, q_dec.dst[1:0]}][15:8], r[7:0]};
    else nv = {r[7:0], gr_r[{1'b0, q_dec.dst[1:0]}][7:0]};
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) gr_r[i] <= '0;
      for (int i = 0; i < 4; i++) sr_r[i] <= '0;
      fl_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (take) begin
        fl_r <= fl_nxt;
        if (rw) begin
          if (q_dec.dst[4]) sr_r[q_dec.dst[1:0]] <= nv;
          else gr_r[q_dec.dst[3] ? {1'b0, q_dec.dst[1:0]} : q_dec.dst[2:0]] <= nv;
        end
      end
      if (take) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (take)
      od_r <= {6'd0, fl_nxt[2], fl_nxt[1], fl_nxt[0], fw, rw ? nv : 16'h0,
               rw ? q_dec.dst : 5'd0, rw, q_dec.kind, q_dec.status, q_dec.len};
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[29:9] == 21'd0)
    else $error("register fields without write");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[7:5] == OPK_NONE && out_tdata[2:0] == 3'd0)
    else $error("error result with length");
endmodule

### src/x86_16bit_decode_execute_top.sv
// x86_16bit_decode_execute_top: 16-bit x86 subset decode and execute
// depends on x86de_pkg, x86de_front, x86de_back
//
// in channel: one word per instruction window, tdata = instr_bytes[47:0],
//   bytes_valid[50:48], zero fill to 56 bits
// out channel: one word per input word with length, status, op kind, register
//   write and current zero, sign and parity flags
// the front decodes the window combinationally into a one-entry skid
// register; the back reads the register file, runs one add/subtract and
// writes back and registers the result in the same cycle
// path: an accepted word passes the queue register, then the result register
// throughput: one word per cycle while out_tready stays high; back-to-back
//   instructions see the register writes of the previous one
// reset: general, segment registers and flags clear, both queues empty
// receiver stall: the output word holds, the queue fills, then in_tready
//   drops; no word is lost
module x86_16bit_decode_execute_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // instr_bytes[47:0], bytes_valid[50:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // instr_length, status, op_kind, reg_write,
                                  // dest_reg, dest_value, flags_written,
                                  // zero_flag, sign_flag, parity_flag
);
  import x86de_pkg::*;

  dec_t dec, q_r;
  logic qv_r, q_ready;

  x86de_front u_front (
    .instr_bytes (in_tdata[47:0]),
    .bytes_valid (in_tdata[50:48]),
    .dec         (dec)
  );

  // one-entry queue between front and back
  assign in_tready = ~qv_r | q_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) qv_r <= 1'b0;
    else if (in_tready) qv_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) q_r <= dec;
  end

  x86de_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qv_r),
    .q_ready    (q_ready),
    .q_dec      (q_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
